// ===== src/join_filter_revenue_by_nation_core_macros.svh =====
// ----------------------------------------------------------------------------
// join_filter_revenue_by_nation_core assertion macros
// shorthand for clocked implications under the block reset
// ----------------------------------------------------------------------------
`ifndef JOIN_FILTER_REVENUE_BY_NATION_CORE_MACROS_SVH
`define JOIN_FILTER_REVENUE_BY_NATION_CORE_MACROS_SVH

// same-cycle implication
`define JFRN_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("jfrn same-cycle check failed");

// next-cycle implication
`define JFRN_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("jfrn next-cycle check failed");

`endif

// ===== src/jfrn_pkg.sv =====
// ----------------------------------------------------------------------------
// jfrn_pkg
// shared types and constants of the join, filter and revenue-by-nation core
// ----------------------------------------------------------------------------
`default_nettype none

package jfrn_pkg;

	// default table sizes
	localparam int ORDER_SLOTS_DEF    = 65536;
	localparam int CUSTOMER_SLOTS_DEF = 16384;
	localparam int SUPPLIER_SLOTS_DEF = 1024;
	localparam int NATION_SLOTS_DEF   = 32;

	// field widths
	localparam int REV_W  = 31;
	localparam int SUM_W  = 56;
	localparam int CFG_IDX_W = 2;
	localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_REGION = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_START_DAY     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_END_DAY       = 2'd2;

	typedef enum logic [2:0] {
		OP_LOAD_ORDER  = 3'd0,
		OP_LOAD_CUST   = 3'd1,
		OP_LOAD_SUPP   = 3'd2,
		OP_LOAD_NATION = 3'd3,
		OP_LINE_ITEM   = 3'd4,
		OP_READ_SUM    = 3'd5,
		OP_CLEAR_SUMS  = 3'd6,
		OP_NOP         = 3'd7
	} op_t;

	typedef enum logic [2:0] {
		OUT_DONE         = 3'd0,
		OUT_COUNTED      = 3'd1,
		OUT_MISSING      = 3'd2,
		OUT_DATE_RANGE   = 3'd3,
		OUT_NATIONS_DIFF = 3'd4,
		OUT_OTHER_REGION = 3'd5
	} outc_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC,
		ST_ORD_CHK,
		ST_CS_CHK,
		ST_NAT_CHK,
		ST_READ,
		ST_PUT
	} state_t;

	// classified request held in the queue
	typedef struct packed {
		op_t              op;
		logic             key_ok;
		logic             supp_ok;
		logic [15:0]      order_key;
		logic [13:0]      cust_key;
		logic [9:0]       supp_key;
		logic [4:0]       nation_key;
		logic [4:0]       region_key;
		logic [15:0]      order_day;
		logic [REV_W-1:0] rev;
	} q_item_t;

	typedef struct packed {
		logic        valid;
		logic [13:0] cust;
		logic [15:0] day;
	} ord_ent_t;

	typedef struct packed {
		logic       valid;
		logic [4:0] code;
	} tab_ent_t;

	typedef struct packed {
		logic [4:0]  target_region;
		logic [15:0] start_day;
		logic [15:0] end_day;
	} cfg_t;

endpackage

`default_nettype wire

// ===== src/join_filter_revenue_by_nation_core.sv =====
// ----------------------------------------------------------------------------
// join_filter_revenue_by_nation_core: order/customer/supplier join, sum by nation
// path: result goes through the queue, the lookup sequencer and the output register
// requests wait in a two-entry queue while the sequencer handles one at a time; line items
//   walk the chained order, customer/supplier and nation lookups
// reset: valid marks of the order, customer and supplier tables are swept clear and no
//   request is taken until the sweep ends; sums read as zero
// ----------------------------------------------------------------------------
`default_nettype none
`include "join_filter_revenue_by_nation_core_macros.svh"

module join_filter_revenue_by_nation_core #(
	parameter int ORDER_SLOTS    = jfrn_pkg::ORDER_SLOTS_DEF,
	parameter int CUSTOMER_SLOTS = jfrn_pkg::CUSTOMER_SLOTS_DEF,
	parameter int SUPPLIER_SLOTS = jfrn_pkg::SUPPLIER_SLOTS_DEF,
	parameter int NATION_SLOTS   = jfrn_pkg::NATION_SLOTS_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// order_key, cust_key, supp_key, nation_key, region_key, order_day,
	// price_cents, discount_pct, zero pad
	input  wire logic [103:0] s_tdata,
	// operation
	input  wire logic [2:0]   s_tuser,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// result_nation, amount, zero pad
	output logic [63:0]       m_tdata,
	// outcome
	output logic [2:0]        m_tuser,
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [jfrn_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [15:0]  cfg_data
);

	jfrn_pkg::cfg_t    cfg_q;
	jfrn_pkg::q_item_t push_item, pop_item;
	logic push, push_ready, pop, pop_valid, clear_done;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				jfrn_pkg::REG_TARGET_REGION: cfg_q.target_region <= cfg_data[4:0];
				jfrn_pkg::REG_START_DAY:     cfg_q.start_day     <= cfg_data;
				jfrn_pkg::REG_END_DAY:       cfg_q.end_day       <= cfg_data;
				default: ;
			endcase
		end
	end

	jfrn_front #(
		.ORDER_SLOTS(ORDER_SLOTS), .CUSTOMER_SLOTS(CUSTOMER_SLOTS),
		.SUPPLIER_SLOTS(SUPPLIER_SLOTS), .NATION_SLOTS(NATION_SLOTS)
	) u_front (
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.clear_done(clear_done), .q_ready(push_ready), .q_push(push), .q_item(push_item)
	);

	jfrn_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .push_item(push_item),
		.push_ready(push_ready), .pop(pop), .pop_valid(pop_valid), .pop_item(pop_item)
	);

	jfrn_back #(
		.ORDER_SLOTS(ORDER_SLOTS), .CUSTOMER_SLOTS(CUSTOMER_SLOTS),
		.SUPPLIER_SLOTS(SUPPLIER_SLOTS), .NATION_SLOTS(NATION_SLOTS)
	) u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q), .q_valid(pop_valid), .q_item(pop_item),
		.q_pop(pop), .clear_done(clear_done), .m_tvalid(m_tvalid), .m_tready(m_tready),
		.m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	// no request taken during the clearing sweep
	`JFRN_ASSERT_IMPL(a_no_accept_clearing, !clear_done, !s_tready)
	// rejected line items carry no nation and no amount
	`JFRN_ASSERT_IMPL(a_reject_zero, m_tvalid && m_tuser > jfrn_pkg::OUT_COUNTED, m_tdata == 64'd0)
	// end day write lands in the register
	`JFRN_ASSERT_NEXT(a_cfg_end_day, cfg_valid && cfg_ready && cfg_index == jfrn_pkg::REG_END_DAY, cfg_q.end_day == $past(cfg_data))

endmodule

`default_nettype wire

// ===== src/jfrn_front.sv =====
// ----------------------------------------------------------------------------
// jfrn_front
// accepts requests, range-checks keys and precomputes the discounted revenue
// ----------------------------------------------------------------------------
`default_nettype none

module jfrn_front #(
	parameter int ORDER_SLOTS    = jfrn_pkg::ORDER_SLOTS_DEF,
	parameter int CUSTOMER_SLOTS = jfrn_pkg::CUSTOMER_SLOTS_DEF,
	parameter int SUPPLIER_SLOTS = jfrn_pkg::SUPPLIER_SLOTS_DEF,
	parameter int NATION_SLOTS   = jfrn_pkg::NATION_SLOTS_DEF
) (
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic [103:0]      s_tdata,
	input  wire logic [2:0]        s_tuser,
	input  wire logic              clear_done,
	input  wire logic              q_ready,
	output logic                   q_push,
	output jfrn_pkg::q_item_t      q_item
);

	logic [6:0] disc;
	logic [6:0] keep;
	logic       ord_in, cust_in, supp_in, nat_in;

	assign s_tready = q_ready & clear_done;
	assign q_push   = s_tvalid & s_tready;

	// key range checks
	assign ord_in  = 32'(s_tdata[15:0])  < 32'(ORDER_SLOTS);
	assign cust_in = 32'(s_tdata[29:16]) < 32'(CUSTOMER_SLOTS);
	assign supp_in = 32'(s_tdata[39:30]) < 32'(SUPPLIER_SLOTS);
	assign nat_in  = 32'(s_tdata[44:40]) < 32'(NATION_SLOTS);

	always_comb begin
		// unpack fields
		q_item.op         = jfrn_pkg::op_t'(s_tuser);
		q_item.order_key  = s_tdata[15:0];
		q_item.cust_key   = s_tdata[29:16];
		q_item.supp_key   = s_tdata[39:30];
		q_item.nation_key = s_tdata[44:40];
		q_item.region_key = s_tdata[49:45];
		q_item.order_day  = s_tdata[65:50];
		disc              = s_tdata[96:90];

		// key check per operation
		case (jfrn_pkg::op_t'(s_tuser))
			jfrn_pkg::OP_LOAD_ORDER, jfrn_pkg::OP_LINE_ITEM: q_item.key_ok = ord_in;
			jfrn_pkg::OP_LOAD_CUST:                          q_item.key_ok = cust_in;
			jfrn_pkg::OP_LOAD_SUPP:                          q_item.key_ok = supp_in;
			default:                                         q_item.key_ok = nat_in;
		endcase
		q_item.supp_ok = supp_in;

		// revenue with discount clamped to 100
		keep       = (disc > 7'd100) ? 7'd0 : (7'd100 - disc);
		q_item.rev = jfrn_pkg::REV_W'(s_tdata[89:66]) * jfrn_pkg::REV_W'(keep);
	end

endmodule

`default_nettype wire

// ===== src/jfrn_queue.sv =====
// ----------------------------------------------------------------------------
// jfrn_queue
// two-entry queue between the front and the back end
// ----------------------------------------------------------------------------
`default_nettype none

module jfrn_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire jfrn_pkg::q_item_t push_item,
	output logic                   push_ready,
	input  wire logic              pop,
	output logic                   pop_valid,
	output jfrn_pkg::q_item_t      pop_item
);

	jfrn_pkg::q_item_t mem_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;

	assign push_ready = cnt_q != 2'd2;
	assign pop_valid  = cnt_q != 2'd0;
	assign pop_item   = mem_q[rd_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop)  rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_item;
	end

endmodule

`default_nettype wire

// ===== src/jfrn_back.sv =====
// ----------------------------------------------------------------------------
// jfrn_back
// table memories, lookup sequencer, per-nation sums and output register
// ----------------------------------------------------------------------------
`default_nettype none

module jfrn_back #(
	parameter int ORDER_SLOTS    = jfrn_pkg::ORDER_SLOTS_DEF,
	parameter int CUSTOMER_SLOTS = jfrn_pkg::CUSTOMER_SLOTS_DEF,
	parameter int SUPPLIER_SLOTS = jfrn_pkg::SUPPLIER_SLOTS_DEF,
	parameter int NATION_SLOTS   = jfrn_pkg::NATION_SLOTS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire jfrn_pkg::cfg_t    cfg,
	input  wire logic              q_valid,
	input  wire jfrn_pkg::q_item_t q_item,
	output logic                   q_pop,
	output logic                   clear_done,
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic [63:0]            m_tdata,
	output logic [2:0]             m_tuser
);

	localparam int OAW = $clog2(ORDER_SLOTS);
	localparam int CAW = $clog2(CUSTOMER_SLOTS);
	localparam int SAW = $clog2(SUPPLIER_SLOTS);
	localparam int NAW = (NATION_SLOTS > 1) ? $clog2(NATION_SLOTS) : 1;
	localparam int CLR_A = (ORDER_SLOTS > CUSTOMER_SLOTS) ? ORDER_SLOTS : CUSTOMER_SLOTS;
	localparam int CLR_LEN = (CLR_A > SUPPLIER_SLOTS) ? CLR_A : SUPPLIER_SLOTS;
	localparam int CLW = $clog2(CLR_LEN + 1);

	jfrn_pkg::state_t  state_q, state_d;
	jfrn_pkg::q_item_t item_q;
	logic [CLW-1:0]    clr_q;
	logic              clearing;

	// table memories
	jfrn_pkg::ord_ent_t ord_mem  [ORDER_SLOTS];
	jfrn_pkg::tab_ent_t cust_mem [CUSTOMER_SLOTS];
	jfrn_pkg::tab_ent_t supp_mem [SUPPLIER_SLOTS];
	logic [4:0]              nat_mem [NATION_SLOTS];
	logic [jfrn_pkg::SUM_W-1:0] rev_mem [NATION_SLOTS];
	logic [NATION_SLOTS-1:0] nat_vld_q, rev_vld_q;

	jfrn_pkg::ord_ent_t ord_rd_q, ord_wd;
	jfrn_pkg::tab_ent_t cust_rd_q, supp_rd_q, cust_wd, supp_wd;
	logic [4:0]         nat_rd_q;
	logic               nat_vld_rd_q, rev_vld_rd_q;
	logic [jfrn_pkg::SUM_W-1:0] rev_rd_q;
	logic               ord_we, cust_we, supp_we;
	logic [OAW-1:0]     ord_wa;
	logic [CAW-1:0]     cust_wa, cust_ra;
	logic [SAW-1:0]     supp_wa;
	logic [4:0]         nat_addr;
	logic [NAW-1:0]     nat_idx;
	logic               cust_in_q, nat_in_q;
	logic [4:0]         sn_q;

	logic [jfrn_pkg::SUM_W:0]   sum_ext;
	logic [jfrn_pkg::SUM_W-1:0] sum_cur, sum_new;

	// result staging and output register
	logic               res_load;
	jfrn_pkg::outc_t    res_outc, res_outc_q, out_outc_q;
	logic [4:0]         res_nat, res_nat_q, out_nat_q;
	logic [jfrn_pkg::SUM_W-1:0] res_amt, res_amt_q, out_amt_q;
	logic               out_vld_q, out_load;

	assign clearing   = state_q == jfrn_pkg::ST_CLEAR;
	assign clear_done = !clearing;

	// write ports: clearing pass or load requests
	always_comb begin
		ord_we  = clearing ? (32'(clr_q) < 32'(ORDER_SLOTS)) :
			(state_q == jfrn_pkg::ST_EXEC && item_q.op == jfrn_pkg::OP_LOAD_ORDER &&
			 item_q.key_ok);
		cust_we = clearing ? (32'(clr_q) < 32'(CUSTOMER_SLOTS)) :
			(state_q == jfrn_pkg::ST_EXEC && item_q.op == jfrn_pkg::OP_LOAD_CUST &&
			 item_q.key_ok);
		supp_we = clearing ? (32'(clr_q) < 32'(SUPPLIER_SLOTS)) :
			(state_q == jfrn_pkg::ST_EXEC && item_q.op == jfrn_pkg::OP_LOAD_SUPP &&
			 item_q.key_ok);
		ord_wa  = clearing ? OAW'(clr_q) : OAW'(item_q.order_key);
		cust_wa = clearing ? CAW'(clr_q) : CAW'(item_q.cust_key);
		supp_wa = clearing ? SAW'(clr_q) : SAW'(item_q.supp_key);
		ord_wd.valid  = !clearing;
		ord_wd.cust   = item_q.cust_key;
		ord_wd.day    = item_q.order_day;
		cust_wd.valid = !clearing;
		cust_wd.code  = item_q.nation_key;
		supp_wd.valid = !clearing;
		supp_wd.code  = item_q.nation_key;
	end

	// read addresses
	assign cust_ra  = CAW'(ord_rd_q.cust);
	assign nat_addr = (state_q == jfrn_pkg::ST_CS_CHK) ? cust_rd_q.code : item_q.nation_key;
	assign nat_idx  = NAW'(nat_addr);

	// memories with registered reads
	always_ff @(posedge clk) begin
		if (ord_we)  ord_mem[ord_wa]   <= ord_wd;
		if (cust_we) cust_mem[cust_wa] <= cust_wd;
		if (supp_we) supp_mem[supp_wa] <= supp_wd;
		ord_rd_q  <= ord_mem[OAW'(item_q.order_key)];
		cust_rd_q <= cust_mem[cust_ra];
		supp_rd_q <= supp_mem[SAW'(item_q.supp_key)];
	end

	// nation table and sums
	always_ff @(posedge clk) begin
		if (state_q == jfrn_pkg::ST_EXEC && item_q.op == jfrn_pkg::OP_LOAD_NATION &&
		    item_q.key_ok)
			nat_mem[NAW'(item_q.nation_key)] <= item_q.region_key;
		if (state_q == jfrn_pkg::ST_NAT_CHK && res_outc == jfrn_pkg::OUT_COUNTED)
			rev_mem[NAW'(sn_q)] <= sum_new;
		nat_rd_q     <= nat_mem[nat_idx];
		rev_rd_q     <= rev_mem[nat_idx];
		nat_vld_rd_q <= nat_vld_q[nat_idx];
		rev_vld_rd_q <= rev_vld_q[nat_idx];
	end

	// valid marks of the small tables
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nat_vld_q <= '0;
			rev_vld_q <= '0;
		end else begin
			if (state_q == jfrn_pkg::ST_EXEC && item_q.op == jfrn_pkg::OP_LOAD_NATION &&
			    item_q.key_ok)
				nat_vld_q[NAW'(item_q.nation_key)] <= 1'b1;
			if (state_q == jfrn_pkg::ST_EXEC && item_q.op == jfrn_pkg::OP_CLEAR_SUMS)
				rev_vld_q <= '0;
			else if (state_q == jfrn_pkg::ST_NAT_CHK && res_outc == jfrn_pkg::OUT_COUNTED)
				rev_vld_q[NAW'(sn_q)] <= 1'b1;
		end
	end

	// saturating accumulate
	assign sum_cur = rev_vld_rd_q ? rev_rd_q : '0;
	assign sum_ext = {1'b0, sum_cur} + (jfrn_pkg::SUM_W + 1)'(item_q.rev);
	assign sum_new = sum_ext[jfrn_pkg::SUM_W] ? jfrn_pkg::SUM_MAX :
		sum_ext[jfrn_pkg::SUM_W-1:0];

	// sequencer state register and lookup side registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= jfrn_pkg::ST_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (clearing) clr_q <= clr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) item_q <= q_item;
		if (state_q == jfrn_pkg::ST_ORD_CHK)
			cust_in_q <= 32'(ord_rd_q.cust) < 32'(CUSTOMER_SLOTS);
		if (state_q == jfrn_pkg::ST_CS_CHK) begin
			nat_in_q <= 32'(cust_rd_q.code) < 32'(NATION_SLOTS);
			sn_q     <= cust_rd_q.code;
		end
		if (res_load) begin
			res_outc_q <= res_outc;
			res_nat_q  <= res_nat;
			res_amt_q  <= res_amt;
		end
	end

	// next state and result selection
	always_comb begin
		state_d  = state_q;
		q_pop    = 1'b0;
		res_load = 1'b0;
		res_outc = jfrn_pkg::OUT_DONE;
		res_nat  = '0;
		res_amt  = '0;
		out_load = 1'b0;
		unique case (state_q)
			jfrn_pkg::ST_CLEAR: begin
				if (clr_q == CLW'(CLR_LEN - 1)) state_d = jfrn_pkg::ST_IDLE;
			end
			jfrn_pkg::ST_IDLE: begin
				if (q_valid) begin
					q_pop   = 1'b1;
					state_d = jfrn_pkg::ST_EXEC;
				end
			end
			jfrn_pkg::ST_EXEC: begin
				case (item_q.op)
					jfrn_pkg::OP_LINE_ITEM: begin
						if (item_q.key_ok) begin
							state_d = jfrn_pkg::ST_ORD_CHK;
						end else begin
							res_load = 1'b1;
							res_outc = jfrn_pkg::OUT_MISSING;
							state_d  = jfrn_pkg::ST_PUT;
						end
					end
					jfrn_pkg::OP_READ_SUM: state_d = jfrn_pkg::ST_READ;
					default: begin
						res_load = 1'b1;
						state_d  = jfrn_pkg::ST_PUT;
					end
				endcase
			end
			jfrn_pkg::ST_ORD_CHK: begin
				if (!ord_rd_q.valid) begin
					res_load = 1'b1;
					res_outc = jfrn_pkg::OUT_MISSING;
					state_d  = jfrn_pkg::ST_PUT;
				end else if (ord_rd_q.day < cfg.start_day || ord_rd_q.day >= cfg.end_day) begin
					res_load = 1'b1;
					res_outc = jfrn_pkg::OUT_DATE_RANGE;
					state_d  = jfrn_pkg::ST_PUT;
				end else begin
					state_d = jfrn_pkg::ST_CS_CHK;
				end
			end
			jfrn_pkg::ST_CS_CHK: begin
				if (!cust_in_q || !cust_rd_q.valid || !item_q.supp_ok || !supp_rd_q.valid) begin
					res_load = 1'b1;
					res_outc = jfrn_pkg::OUT_MISSING;
					state_d  = jfrn_pkg::ST_PUT;
				end else if (cust_rd_q.code != supp_rd_q.code) begin
					res_load = 1'b1;
					res_outc = jfrn_pkg::OUT_NATIONS_DIFF;
					state_d  = jfrn_pkg::ST_PUT;
				end else begin
					state_d = jfrn_pkg::ST_NAT_CHK;
				end
			end
			jfrn_pkg::ST_NAT_CHK: begin
				res_load = 1'b1;
				state_d  = jfrn_pkg::ST_PUT;
				if (!nat_in_q || !nat_vld_rd_q) begin
					res_outc = jfrn_pkg::OUT_MISSING;
				end else if (nat_rd_q != cfg.target_region) begin
					res_outc = jfrn_pkg::OUT_OTHER_REGION;
				end else begin
					res_outc = jfrn_pkg::OUT_COUNTED;
					res_nat  = sn_q;
					res_amt  = jfrn_pkg::SUM_W'(item_q.rev);
				end
			end
			jfrn_pkg::ST_READ: begin
				res_load = 1'b1;
				res_nat  = item_q.nation_key;
				res_amt  = item_q.key_ok ? sum_cur : '0;
				state_d  = jfrn_pkg::ST_PUT;
			end
			jfrn_pkg::ST_PUT: begin
				if (!out_vld_q || m_tready) begin
					out_load = 1'b1;
					state_d  = jfrn_pkg::ST_IDLE;
				end
			end
			default: state_d = jfrn_pkg::ST_IDLE;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_load) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_outc_q <= res_outc_q;
			out_nat_q  <= res_nat_q;
			out_amt_q  <= res_amt_q;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tuser  = out_outc_q;
	assign m_tdata  = {3'b000, out_amt_q, out_nat_q};

endmodule

`default_nettype wire
